// ===== hdl/png_unf_pkg.sv =====
package png_unf_pkg;

    // Field widths fixed by the pixel format.
    localparam int CH_W         = 8;
    localparam int NUM_CH       = 4;
    localparam int PIX_W        = CH_W * NUM_CH;
    localparam int FILT_W       = 3;
    localparam int ROW_PIXELS_W = 13;

    localparam logic [ROW_PIXELS_W-1:0] ROW_PIXELS_RST = ROW_PIXELS_W'(640);
    localparam int MAX_ROW_PIXELS_DEF = 4096;

    // Row filter codes; anything above FILT_PAETH is invalid.
    localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

    // One reconstructed word as it travels through the output buffer.
    typedef struct packed {
        logic             bad;
        logic             last;
        logic [PIX_W-1:0] rgba;
    } t_pix_out;

endpackage

// ===== hdl/png_unf_lane.sv =====
module png_unf_lane (
    input  logic [png_unf_pkg::FILT_W-1:0] i_ftype,
    input  logic [png_unf_pkg::CH_W-1:0]   i_x,
    input  logic [png_unf_pkg::CH_W-1:0]   i_a,
    input  logic [png_unf_pkg::CH_W-1:0]   i_b,
    input  logic [png_unf_pkg::CH_W-1:0]   i_c,
    output logic [png_unf_pkg::CH_W-1:0]   o_y
);
    import png_unf_pkg::*;

    logic [CH_W:0]          avg_sum;
    logic signed [CH_W+1:0] d_a;
    logic signed [CH_W+1:0] d_b;
    logic signed [CH_W+1:0] d_c;
    logic [CH_W+1:0]        pa;
    logic [CH_W+1:0]        pb;
    logic [CH_W+1:0]        pc;
    logic [CH_W-1:0]        paeth;
    logic [CH_W-1:0]        pred;

    assign avg_sum = {1'b0, i_a} + {1'b0, i_b};

    // With p = a + b - c: p - a = b - c, p - b = a - c, p - c = a + b - 2c.
    assign d_a = $signed({2'b00, i_b}) - $signed({2'b00, i_c});
    assign d_b = $signed({2'b00, i_a}) - $signed({2'b00, i_c});
    assign d_c = $signed({2'b00, i_a}) + $signed({2'b00, i_b})
               - $signed({1'b0, i_c, 1'b0});

    assign pa = d_a[CH_W+1] ? $unsigned(-d_a) : $unsigned(d_a);
    assign pb = d_b[CH_W+1] ? $unsigned(-d_b) : $unsigned(d_b);
    assign pc = d_c[CH_W+1] ? $unsigned(-d_c) : $unsigned(d_c);

    // Ties favor the left byte, then the byte above.
    always_comb begin
        if (pa <= pb && pa <= pc) begin
            paeth = i_a;
        end else if (pb <= pc) begin
            paeth = i_b;
        end else begin
            paeth = i_c;
        end
    end

    always_comb begin
        unique case (i_ftype)
            FILT_SUB:   pred = i_a;
            FILT_UP:    pred = i_b;
            FILT_AVG:   pred = avg_sum[CH_W:1];
            FILT_PAETH: pred = paeth;
            default:    pred = '0;
        endcase
    end

    assign o_y = i_x + pred;

endmodule

// ===== hdl/png_unf_linebuf.sv =====
module png_unf_linebuf #(
    parameter int DEPTH = png_unf_pkg::MAX_ROW_PIXELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [png_unf_pkg::PIX_W-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [png_unf_pkg::PIX_W-1:0] o_rd_data
);
    import png_unf_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A one-pixel row reads back the column it writes in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && i_wr_addr == i_rd_addr) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== hdl/png_unf_skid.sv =====
module png_unf_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  png_unf_pkg::t_pix_out i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output png_unf_pkg::t_pix_out o_word
);
    import png_unf_pkg::*;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_pix_out r_out;
    t_pix_out r_skid;
    logic     out_free;
    logic     in_acc;

    assign o_ready  = !r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_free = i_ready || !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_word;
        end else if (in_acc) begin
            r_skid <= i_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

// ===== hdl/png_scanline_unfilter_rgba8_core.sv =====
// Channel   Dir  Handshake             Contents
// s_axis    in   tvalid/tready         tdata: red, green, blue, alpha; tuser: first, filter
// m_axis    out  tvalid/tready         tdata: red, green, blue, alpha; tlast: row end;
//                                      tuser: bad filter
// cfg       in   i_cfg_we              i_cfg_wdata: pixels per row
//
// One pixel word per cycle while the output buffer has room; each result is registered before it appears.
// The left-pixel feedback through the four channel lanes sets the single-cycle rate; the
// line buffer is read one word ahead at the next column, so its latency is hidden.
// A two-entry output buffer keeps the input side moving for one stalled output word.
// Reset is synchronous and active low; the line buffer is not cleared.
module png_scanline_unfilter_rgba8_core #(
    parameter int MAX_ROW_PIXELS = png_unf_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [png_unf_pkg::ROW_PIXELS_W-1:0] i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata,  // red, green, blue, alpha
    input  logic [3:0]                           s_axis_tuser,  // first_of_image, filter code
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [31:0]                          m_axis_tdata,  // red, green, blue, alpha
    output logic                                 m_axis_tlast,
    output logic [0:0]                           m_axis_tuser   // bad_filter
);
    import png_unf_pkg::*;

    localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
    localparam int CW = $clog2(MAX_ROW_PIXELS + 1);
    localparam int LW = (CW > ROW_PIXELS_W) ? CW : ROW_PIXELS_W;

    logic [ROW_PIXELS_W-1:0] r_row_pixels;
    logic [AW-1:0]           r_col;
    logic                    r_first_row;
    logic [PIX_W-1:0]        r_left;
    logic [PIX_W-1:0]        r_upleft;

    logic              accept;
    logic              sof;
    logic [FILT_W-1:0] ftype;
    logic              bad;
    logic [AW-1:0]     col;
    logic              first_row;
    logic [LW-1:0]     rp_ext;
    logic [LW-1:0]     eff_len;
    logic [LW-1:0]     col_p1;
    logic              last;
    logic [AW-1:0]     n_col;
    logic [PIX_W-1:0]  lb_rd;
    logic [PIX_W-1:0]  above;
    logic [PIX_W-1:0]  left;
    logic [PIX_W-1:0]  upleft;
    logic [PIX_W-1:0]  lane_out;
    logic [PIX_W-1:0]  result;
    t_pix_out          word_in;
    t_pix_out          word_out;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign sof    = s_axis_tuser[0];
    assign ftype  = s_axis_tuser[3:1];
    assign bad    = ftype > FILT_PAETH;

    // A new image restarts at column zero with an all-zero prior row.
    assign col       = sof ? '0 : r_col;
    assign first_row = sof || r_first_row;

    always_comb begin
        rp_ext = LW'(r_row_pixels);
        if (rp_ext == '0) begin
            eff_len = LW'(1);
        end else if (rp_ext > LW'(MAX_ROW_PIXELS)) begin
            eff_len = LW'(MAX_ROW_PIXELS);
        end else begin
            eff_len = rp_ext;
        end
    end

    assign col_p1 = LW'(col) + LW'(1);
    assign last   = col_p1 >= eff_len;
    assign n_col  = last ? '0 : col_p1[AW-1:0];

    png_unf_linebuf #(
        .DEPTH (MAX_ROW_PIXELS),
        .AW    (AW)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (col),
        .i_wr_data (result),
        .i_rd_en   (accept),
        .i_rd_addr (n_col),
        .o_rd_data (lb_rd)
    );

    assign above  = first_row ? '0 : lb_rd;
    assign left   = (col == '0) ? '0 : r_left;
    assign upleft = (col == '0 || first_row) ? '0 : r_upleft;

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        png_unf_lane u_lane (
            .i_ftype (ftype),
            .i_x     (s_axis_tdata[g*CH_W +: CH_W]),
            .i_a     (left[g*CH_W +: CH_W]),
            .i_b     (above[g*CH_W +: CH_W]),
            .i_c     (upleft[g*CH_W +: CH_W]),
            .o_y     (lane_out[g*CH_W +: CH_W])
        );
    end

    // Merge the lanes; an invalid filter yields an all-zero pixel.
    assign result = bad ? '0 : lane_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pixels <= ROW_PIXELS_RST;
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_left       <= '0;
            r_upleft     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_row_pixels <= i_cfg_wdata;
            end
            if (accept) begin
                r_col       <= n_col;
                r_first_row <= first_row && !last;
                r_left      <= result;
                r_upleft    <= above;
            end
        end
    end

    assign word_in.bad  = bad;
    assign word_in.last = last;
    assign word_in.rgba = result;

    png_unf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (word_in),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (word_out)
    );

    assign m_axis_tdata    = word_out.rgba;
    assign m_axis_tlast    = word_out.last;
    assign m_axis_tuser[0] = word_out.bad;

`ifndef SYNTHESIS
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while the output register is empty");

    a_row_end_leaves_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last |=> !r_first_row && r_col == '0)
        else $error("row end did not advance the row tracking");

    a_first_row_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && sof && !last |=> r_first_row)
        else $error("first row flag lost within the first row");

    a_bad_zero_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && bad |=> r_left == '0)
        else $error("invalid filter stored a nonzero left pixel");
`endif

endmodule
